FILE: hdl/c8x_pkg.sv
package c8x_pkg;

   // fixed geometry of memory and screen
   localparam int ADDR_W   = 12;
   localparam int MEM_BYTES = 4096;
   localparam int SCR_ROWS = 32;
   localparam int SCR_COLS = 64;
   localparam int ROW_W    = 5;

   // item kinds
   localparam logic [1:0] ACT_EXEC  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_ROW   = 2'd3;

   // opcode groups (top nibble)
   localparam logic [3:0] OPG_SYS  = 4'h0;
   localparam logic [3:0] OPG_JP   = 4'h1;
   localparam logic [3:0] OPG_CALL = 4'h2;
   localparam logic [3:0] OPG_SE   = 4'h3;
   localparam logic [3:0] OPG_SNE  = 4'h4;
   localparam logic [3:0] OPG_SER  = 4'h5;
   localparam logic [3:0] OPG_LD   = 4'h6;
   localparam logic [3:0] OPG_ADD  = 4'h7;
   localparam logic [3:0] OPG_ALU  = 4'h8;
   localparam logic [3:0] OPG_SNER = 4'h9;
   localparam logic [3:0] OPG_LDI  = 4'hA;
   localparam logic [3:0] OPG_JPV  = 4'hB;
   localparam logic [3:0] OPG_RND  = 4'hC;
   localparam logic [3:0] OPG_DRW  = 4'hD;
   localparam logic [3:0] OPG_KEY  = 4'hE;
   localparam logic [3:0] OPG_MISC = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   localparam logic [7:0] MSC_GETDT = 8'h07;
   localparam logic [7:0] MSC_WAITK = 8'h0A;
   localparam logic [7:0] MSC_SETDT = 8'h15;
   localparam logic [7:0] MSC_SETST = 8'h18;
   localparam logic [7:0] MSC_ADDI  = 8'h1E;
   localparam logic [7:0] MSC_FONT  = 8'h29;
   localparam logic [7:0] MSC_BCD   = 8'h33;
   localparam logic [7:0] MSC_STORE = 8'h55;
   localparam logic [7:0] MSC_LOAD  = 8'h65;

   // instruction classes seen by the sequencer
   localparam logic [2:0] CLS_SIMPLE = 3'd0;
   localparam logic [2:0] CLS_FLAG   = 3'd1;
   localparam logic [2:0] CLS_BCD    = 3'd2;
   localparam logic [2:0] CLS_STORE  = 3'd3;
   localparam logic [2:0] CLS_LOAD   = 3'd4;
   localparam logic [2:0] CLS_DRAW   = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] opcode;
      logic [15:0] keys_down;
      logic        key_event_valid;
      logic [3:0]  key_event_code;
      logic [7:0]  random_byte;
      logic [11:0] mem_address;
      logic [7:0]  mem_write_data;
      logic [4:0]  screen_row_select;
   } item_type;

   typedef struct packed {
      logic [11:0] program_counter;
      logic [15:0] index_value;
      logic [7:0]  read_byte;
      logic [63:0] row_pixels;
      logic        redraw;
      logic        stack_fault;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
   } res_type;

   typedef struct packed {
      logic load_item;
      logic rd_regs;
      logic exec;
      logic wr_flag;
      logic bcd_wr;
      logic st_rd;
      logic st_wr;
      logic ld_rd;
      logic ld_wr;
      logic dr_rd;
      logic dr_wr;
      logic clr_wr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] op_cls;
      logic       cnt_last;
      logic       draw_empty;
      logic       clr_last;
      logic       out_free;
   } stat_type;

   function automatic logic [2:0] op_class(input logic [15:0] op);
      logic [2:0] c;
      c = CLS_SIMPLE;
      unique case (op[15:12])
         OPG_ALU: begin
            case (op[3:0]) inside
               ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: c = CLS_FLAG;
               default: c = CLS_SIMPLE;
            endcase
         end
         OPG_DRW: c = CLS_DRAW;
         OPG_MISC: begin
            case (op[7:0])
               MSC_BCD:   c = CLS_BCD;
               MSC_STORE: c = CLS_STORE;
               MSC_LOAD:  c = CLS_LOAD;
               default:   c = CLS_SIMPLE;
            endcase
         end
         default: c = CLS_SIMPLE;
      endcase
      return c;
   endfunction

   // {hundreds, tens, ones}
   function automatic logic [11:0] bcd8(input logic [7:0] v);
      logic [1:0]  h;
      logic [7:0]  r;
      logic [15:0] p;
      logic [3:0]  t;
      logic [7:0]  o;
      h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      r = v - 8'(h * 8'd100);
      p = 16'(r) * 16'd205;
      t = p[14:11];
      o = r - 8'(t * 8'd10);
      return {2'b00, h, t, o[3:0]};
   endfunction

endpackage

FILE: hdl/chip8_execute_unit_top.sv
// CHIP-8 instruction execute unit.
// Input channel req_*: one item per instruction or maintenance access.
//   req_tuser is the item kind (execute, memory write, memory read, screen row read).
// Result channel rsp_*: exactly one item per input item, in order, carrying pc, index,
//   timers, the read byte or screen row, and the redraw and stack fault flags.
// One item is in flight at a time. Every item passes a register read and an execute
//   step; ALU ops that set VF add a VF write, BCD store writes three digits,
//   register store/load alternate a read and a write per register, and a sprite
//   draw alternates row reads and row writes, then writes VF. The register block
//   walk through the single memory port sets the worst case.
// A new item can be accepted in the cycle after the previous one finishes.
// req_tready is high only while the unit is idle; the next item can be accepted
// while the previous result is still waiting in the output register.
// When rsp_tready is low the finished result waits and the unit stalls before
// loading the output register again.
// After reset, a pass over all 4096 bytes zeroes main memory; req_tready stays low until
// it finishes. Registers, timers, stack and screen are cleared at once.
module chip8_execute_unit_top #(
   parameter int STACK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   // opcode[15:0], keys_down[31:16], key_event_valid[32], key_event_code[36:33],
   // random_byte[44:37], mem_address[56:45], mem_write_data[64:57],
   // screen_row_select[69:65], zero pad[71:70]
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // program_counter[11:0], index_value[27:12], read_byte[35:28],
   // row_pixels[99:36], redraw[100], stack_fault[101], delay_value[109:102],
   // sound_value[117:110], zero pad[119:118]
   output logic [119:0] rsp_tdata
);
   import c8x_pkg::*;

   item_type item;
   res_type  res;
   cmd_type  cmd;
   stat_type stat;

   always_comb begin
      item.action            = req_tuser;
      item.opcode            = req_tdata[15:0];
      item.keys_down         = req_tdata[31:16];
      item.key_event_valid   = req_tdata[32];
      item.key_event_code    = req_tdata[36:33];
      item.random_byte       = req_tdata[44:37];
      item.mem_address       = req_tdata[56:45];
      item.mem_write_data    = req_tdata[64:57];
      item.screen_row_select = req_tdata[69:65];
   end

   assign rsp_tdata = {2'b00, res.sound_value, res.delay_value, res.stack_fault,
                       res.redraw, res.row_pixels, res.read_byte, res.index_value,
                       res.program_counter};

   c8x_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   c8x_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .item       (item),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .res        (res)
   );

   // the memory clear pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready) else $error("input accepted during memory clear");

   // one item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("back to back accept");

   // a stack fault and a draw cannot come from the same instruction
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[100] && rsp_tdata[101]))
      else $error("redraw and stack fault both set");

endmodule

FILE: hdl/c8x_ctrl.sv
module c8x_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  c8x_pkg::stat_type  stat,
   output c8x_pkg::cmd_type   cmd
);
   import c8x_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_EXEC  = 4'd3;
   localparam logic [3:0] ST_FLAG  = 4'd4;
   localparam logic [3:0] ST_BCD   = 4'd5;
   localparam logic [3:0] ST_SRD   = 4'd6;
   localparam logic [3:0] ST_SWR   = 4'd7;
   localparam logic [3:0] ST_LRD   = 4'd8;
   localparam logic [3:0] ST_LWR   = 4'd9;
   localparam logic [3:0] ST_DRD   = 4'd10;
   localparam logic [3:0] ST_DWR   = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_regs = 1'b1;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.action != ACT_EXEC) begin
               state_in = ST_DONE;
            end else begin
               case (stat.op_cls)
                  CLS_FLAG:  state_in = ST_FLAG;
                  CLS_BCD:   state_in = ST_BCD;
                  CLS_STORE: state_in = ST_SRD;
                  CLS_LOAD:  state_in = ST_LRD;
                  CLS_DRAW:  state_in = stat.draw_empty ? ST_FLAG : ST_DRD;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_FLAG: begin
            cmd.wr_flag = 1'b1;
            state_in    = ST_DONE;
         end
         ST_BCD: begin
            cmd.bcd_wr = 1'b1;
            if (stat.cnt_last) state_in = ST_DONE;
         end
         ST_SRD: begin
            cmd.st_rd = 1'b1;
            state_in  = ST_SWR;
         end
         ST_SWR: begin
            cmd.st_wr = 1'b1;
            state_in  = stat.cnt_last ? ST_DONE : ST_SRD;
         end
         ST_LRD: begin
            cmd.ld_rd = 1'b1;
            state_in  = ST_LWR;
         end
         ST_LWR: begin
            cmd.ld_wr = 1'b1;
            state_in  = stat.cnt_last ? ST_DONE : ST_LRD;
         end
         ST_DRD: begin
            cmd.dr_rd = 1'b1;
            state_in  = ST_DWR;
         end
         ST_DWR: begin
            cmd.dr_wr = 1'b1;
            state_in  = stat.cnt_last ? ST_FLAG : ST_DRD;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/c8x_dpath.sv
module c8x_dpath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  c8x_pkg::cmd_type   cmd,
   input  c8x_pkg::item_type  item,
   input  logic               rsp_tready,
   output c8x_pkg::stat_type  stat,
   output logic               rsp_tvalid,
   output c8x_pkg::res_type   res
);
   import c8x_pkg::*;

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   item_type    item_ff;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic        flag_ff, flag_in, redraw_ff, redraw_in, fault_ff, fault_in;
   logic [7:0]  rd_ff, rd_in;
   logic [63:0] row_ff, row_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff;
   res_type     res_ff;

   logic [11:0] stk_ff [STACK_DEPTH];
   logic [7:0]  vreg_ff [16];
   logic [15:0] vval_ff;
   logic [7:0]  ra_ff, rb_ff;
   logic [7:0]  mem_ff [MEM_BYTES];
   logic [7:0]  mem_q_ff;
   logic [63:0] scr_ff [SCR_ROWS];
   logic [SCR_ROWS-1:0] sval_ff;
   logic [63:0] scr_q_ff;
   logic        scr_qv_ff;

   // decoded fields
   logic [3:0]  grp, xa, ya, nib;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [7:0]  vx, vy;
   assign grp = item_ff.opcode[15:12];
   assign xa  = item_ff.opcode[11:8];
   assign ya  = item_ff.opcode[7:4];
   assign nib = item_ff.opcode[3:0];
   assign nn  = item_ff.opcode[7:0];
   assign nnn = item_ff.opcode[11:0];
   assign vx  = ra_ff;
   assign vy  = rb_ff;

   // port controls
   logic        v_we, r_en;
   logic [3:0]  v_wa, ra_a;
   logic [7:0]  v_wd;
   logic        m_we, m_re;
   logic [ADDR_W-1:0] m_wa, m_ra, m_ia;
   logic [7:0]  m_wd;
   logic        s_we, s_clear, s_re;
   logic [ROW_W-1:0] s_a;
   logic [63:0] s_wd;
   logic        stk_we;

   // helpers
   logic [11:0] pc_skip;
   logic [SPW-1:0] sp_m1;
   logic [2:0]  cls;
   logic [7:0]  alu_r;
   logic        alu_f;
   logic        key_held;
   logic [11:0] bcd;
   logic [7:0]  drow;
   logic [63:0] spr_m, old_row, mask;
   logic [127:0] rot;

   assign pc_skip = pc_ff + 12'd2;
   assign sp_m1   = sp_ff - SPW'(1);
   assign cls     = op_class(item_ff.opcode);
   assign key_held = (vx[7:4] == 4'd0) && item_ff.keys_down[vx[3:0]];
   assign bcd     = bcd8(vx);
   assign m_ia    = idx_ff[ADDR_W-1:0] + ADDR_W'(cnt_ff);
   assign drow    = vy + {4'd0, cnt_ff};
   assign spr_m   = {mem_q_ff, 56'd0};
   // sprite lands at column vx and wraps around the row
   assign rot     = {spr_m, spr_m} >> vx[5:0];
   assign mask    = rot[63:0];
   assign old_row = scr_qv_ff ? scr_q_ff : 64'd0;

   always_comb begin
      alu_r = 8'd0;
      alu_f = 1'b0;
      case (nib)
         ALU_MOV: alu_r = vy;
         ALU_OR:  alu_r = vx | vy;
         ALU_AND: alu_r = vx & vy;
         ALU_XOR: alu_r = vx ^ vy;
         ALU_ADD: {alu_f, alu_r} = {1'b0, vx} + {1'b0, vy};
         ALU_SUB: begin
            alu_r = vx - vy;
            alu_f = vx > vy;
         end
         ALU_SHR: begin
            alu_r = {1'b0, vy[7:1]};
            alu_f = vy[0];
         end
         ALU_SUBN: begin
            alu_r = vy - vx;
            alu_f = vy > vx;
         end
         ALU_SHL: begin
            alu_r = {vy[6:0], 1'b0};
            alu_f = vy[7];
         end
         default: alu_r = vx;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;  idx_in = idx_ff;  sp_in = sp_ff;
      dt_in = dt_ff;  st_in = st_ff;
      flag_in = flag_ff;  redraw_in = redraw_ff;  fault_in = fault_ff;
      rd_in = rd_ff;  row_in = row_ff;  cnt_in = cnt_ff;  clr_in = clr_ff;
      v_we = 1'b0;  v_wa = xa;  v_wd = 8'd0;
      m_we = 1'b0;  m_wa = m_ia;  m_wd = 8'd0;
      s_we = 1'b0;  s_clear = 1'b0;  s_wd = 64'd0;
      stk_we = 1'b0;

      r_en = cmd.rd_regs | cmd.st_rd;
      ra_a = cmd.st_rd ? cnt_ff : ((grp == OPG_JPV) ? 4'd0 : xa);
      m_re = cmd.rd_regs | cmd.ld_rd | cmd.dr_rd;
      m_ra = cmd.rd_regs ? item_ff.mem_address[ADDR_W-1:0] : m_ia;
      s_re = cmd.rd_regs | cmd.dr_rd;
      s_a  = cmd.rd_regs ? item_ff.screen_row_select : drow[ROW_W-1:0];

      if (cmd.load_item) begin
         flag_in = 1'b0;  redraw_in = 1'b0;  fault_in = 1'b0;
         rd_in = 8'd0;  row_in = 64'd0;
      end

      if (cmd.clr_wr) begin
         m_we   = 1'b1;
         m_wa   = clr_ff;
         clr_in = clr_ff + ADDR_W'(1);
      end

      if (cmd.exec) begin
         cnt_in = 4'd0;
         unique case (item_ff.action)
            ACT_WRITE: begin
               m_we = 1'b1;
               m_wa = item_ff.mem_address[ADDR_W-1:0];
               m_wd = item_ff.mem_write_data;
            end
            ACT_READ: rd_in = mem_q_ff;
            ACT_ROW: begin
               if (32'(item_ff.screen_row_select) < SCR_ROWS) row_in = old_row;
            end
            ACT_EXEC: begin
               unique case (grp)
                  OPG_SYS: begin
                     if (item_ff.opcode == OP_CLS) begin
                        s_clear = 1'b1;
                     end else if (item_ff.opcode == OP_RET) begin
                        if (sp_ff == '0) begin
                           fault_in = 1'b1;
                        end else begin
                           sp_in = sp_m1;
                           pc_in = stk_ff[sp_m1[SAW-1:0]];
                        end
                     end
                  end
                  OPG_JP: pc_in = nnn;
                  OPG_CALL: begin
                     if (sp_ff < SPW'(STACK_DEPTH)) begin
                        stk_we = 1'b1;
                        sp_in  = sp_ff + SPW'(1);
                        pc_in  = nnn;
                     end else begin
                        fault_in = 1'b1;
                     end
                  end
                  OPG_SE:  if (vx == nn) pc_in = pc_skip;
                  OPG_SNE: if (vx != nn) pc_in = pc_skip;
                  OPG_SER: if (nib == 4'd0 && vx == vy) pc_in = pc_skip;
                  OPG_LD: begin
                     v_we = 1'b1;  v_wd = nn;
                  end
                  OPG_ADD: begin
                     v_we = 1'b1;  v_wd = vx + nn;
                  end
                  OPG_ALU: begin
                     case (nib) inside
                        ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                        ALU_SHR, ALU_SUBN, ALU_SHL: begin
                           v_we    = 1'b1;
                           v_wd    = alu_r;
                           flag_in = alu_f;
                        end
                        default: v_we = 1'b0;
                     endcase
                  end
                  OPG_SNER: if (nib == 4'd0 && vx != vy) pc_in = pc_skip;
                  OPG_LDI: idx_in = {4'd0, nnn};
                  OPG_JPV: pc_in = nnn + {4'd0, vx};
                  OPG_RND: begin
                     v_we = 1'b1;  v_wd = item_ff.random_byte & nn;
                  end
                  OPG_DRW: redraw_in = 1'b1;
                  OPG_KEY: begin
                     if (nn == KEY_DOWN && key_held) pc_in = pc_skip;
                     else if (nn == KEY_UP && !key_held) pc_in = pc_skip;
                  end
                  OPG_MISC: begin
                     case (nn)
                        MSC_GETDT: begin
                           v_we = 1'b1;  v_wd = dt_ff;
                        end
                        MSC_WAITK: begin
                           if (item_ff.key_event_valid) begin
                              v_we = 1'b1;  v_wd = {4'd0, item_ff.key_event_code};
                           end else begin
                              pc_in = pc_ff - 12'd2;
                           end
                        end
                        MSC_SETDT: dt_in = vx;
                        MSC_SETST: st_in = vx;
                        MSC_ADDI:  idx_in = idx_ff + {8'd0, vx};
                        MSC_FONT:  idx_in = 16'(vx) * 16'd5;
                        default:   idx_in = idx_ff;
                     endcase
                  end
                  default: pc_in = pc_ff;
               endcase
            end
            default: rd_in = rd_ff;
         endcase
      end

      if (cmd.wr_flag) begin
         v_we = 1'b1;  v_wa = 4'hF;  v_wd = {7'd0, flag_ff};
      end

      if (cmd.bcd_wr) begin
         m_we   = 1'b1;
         m_wd   = (cnt_ff == 4'd0) ? {4'd0, bcd[11:8]} :
                  (cnt_ff == 4'd1) ? {4'd0, bcd[7:4]} : {4'd0, bcd[3:0]};
         cnt_in = cnt_ff + 4'd1;
      end

      if (cmd.st_wr) begin
         m_we   = 1'b1;
         m_wd   = ra_ff;
         cnt_in = cnt_ff + 4'd1;
      end

      if (cmd.ld_wr) begin
         v_we   = 1'b1;
         v_wa   = cnt_ff;
         v_wd   = mem_q_ff;
         cnt_in = cnt_ff + 4'd1;
      end

      if ((cmd.st_wr | cmd.ld_wr) && stat.cnt_last) begin
         idx_in = idx_ff + {12'd0, xa} + 16'd1;
      end

      if (cmd.dr_wr) begin
         s_we   = 1'b1;
         s_wd   = old_row ^ mask;
         cnt_in = cnt_ff + 4'd1;
         if ((old_row & mask) != 64'd0) flag_in = 1'b1;
      end
   end

   always_comb begin
      stat.action     = item_ff.action;
      stat.op_cls     = cls;
      stat.draw_empty = (nib == 4'd0);
      stat.clr_last   = (clr_ff == {ADDR_W{1'b1}});
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      case (cls)
         CLS_BCD:   stat.cnt_last = (cnt_ff == 4'd2);
         CLS_STORE,
         CLS_LOAD:  stat.cnt_last = (cnt_ff == xa);
         default:   stat.cnt_last = (cnt_ff == nib - 4'd1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;  idx_ff <= '0;  sp_ff <= '0;
         dt_ff <= '0;  st_ff <= '0;
         flag_ff <= 1'b0;  redraw_ff <= 1'b0;  fault_ff <= 1'b0;
         rd_ff <= '0;  row_ff <= '0;  cnt_ff <= '0;  clr_ff <= '0;
         vval_ff <= '0;  sval_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;  idx_ff <= idx_in;  sp_ff <= sp_in;
         dt_ff <= dt_in;  st_ff <= st_in;
         flag_ff <= flag_in;  redraw_ff <= redraw_in;  fault_ff <= fault_in;
         rd_ff <= rd_in;  row_ff <= row_in;  cnt_ff <= cnt_in;  clr_ff <= clr_in;
         if (v_we) vval_ff[v_wa] <= 1'b1;
         if (s_clear) sval_ff <= '0;
         else if (s_we) sval_ff[s_a] <= 1'b1;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= item;
      if (stk_we) stk_ff[sp_ff[SAW-1:0]] <= pc_ff;
      if (v_we) vreg_ff[v_wa] <= v_wd;
      if (r_en) begin
         ra_ff <= vval_ff[ra_a] ? vreg_ff[ra_a] : 8'd0;
         rb_ff <= vval_ff[ya] ? vreg_ff[ya] : 8'd0;
      end
      if (cmd.finish) begin
         res_ff <= '{program_counter: pc_ff, index_value: idx_ff, read_byte: rd_ff,
                     row_pixels: row_ff, redraw: redraw_ff, stack_fault: fault_ff,
                     delay_value: dt_ff, sound_value: st_ff};
      end
   end

   // main memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (m_we) mem_ff[m_wa] <= m_wd;
      if (m_re) mem_q_ff <= mem_ff[m_ra];
   end

   // screen rows; a row not marked valid reads as blank
   always_ff @(posedge clock) begin
      if (s_we) scr_ff[s_a] <= s_wd;
      if (s_re) begin
         scr_q_ff  <= scr_ff[s_a];
         scr_qv_ff <= sval_ff[s_a];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign res        = res_ff;

endmodule

FILE: tb/chip8_execute_unit_top_tb.sv
`timescale 1ns / 1ps

module chip8_execute_unit_top_tb;
   import c8x_pkg::*;

   class c8_scoreboard;
      res_type     exp_q[$];
      int          errors;
      logic [11:0] pc;
      logic [7:0]  v[16];
      logic [15:0] idx;
      logic [11:0] ret_stk[16];
      int          depth;
      logic [7:0]  mem[MEM_BYTES];
      logic [63:0] scr[SCR_ROWS];
      logic [7:0]  dt, st;

      function new();
         pc = '0; idx = '0; depth = 0; dt = '0; st = '0; errors = 0;
         foreach (v[i]) v[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         foreach (scr[i]) scr[i] = '0;
      endfunction

      function void skip(bit c);
         if (c) pc = pc + 12'd2;
      endfunction

      function void run_alu(logic [3:0] x, logic [3:0] y, logic [3:0] sub);
         logic [7:0] vx, vy, r;
         logic       f;
         vx = v[x];
         vy = v[y];
         case (sub)
            ALU_MOV: begin v[x] = vy; return; end
            ALU_OR:  begin v[x] = vx | vy; return; end
            ALU_AND: begin v[x] = vx & vy; return; end
            ALU_XOR: begin v[x] = vx ^ vy; return; end
            ALU_ADD: begin r = vx + vy; f = (9'(vx) + 9'(vy)) > 9'hff; end
            ALU_SUB: begin r = vx - vy; f = vx > vy; end
            ALU_SHR: begin r = vy >> 1; f = vy[0]; end
            ALU_SUBN: begin r = vy - vx; f = vy > vx; end
            ALU_SHL: begin r = vy << 1; f = vy[7]; end
            default: return;
         endcase
         v[x] = r;
         v[15] = {7'd0, f};
      endfunction

      function void draw(logic [3:0] x, logic [3:0] y, logic [3:0] n);
         logic [7:0]  bx, by, bits;
         logic [4:0]  row;
         logic [5:0]  col;
         logic [63:0] m;
         logic        hit;
         bx = v[x];
         by = v[y];
         hit = 0;
         for (int h = 0; h < n; h++) begin
            bits = mem[12'(idx[11:0] + h)];
            row = 5'(by + h);
            for (int w = 0; w < 8; w++) begin
               if (bits[7 - w]) begin
                  col = 6'(bx + w);
                  m = 64'd1 << (63 - col);
                  if ((scr[row] & m) != 0) hit = 1;
                  scr[row] ^= m;
               end
            end
         end
         v[15] = {7'd0, hit};
      endfunction

      function void note_item(item_type it);
         res_type     r;
         logic [15:0] op;
         logic [3:0]  x, y, n;
         logic [7:0]  nn, k;
         logic [11:0] nnn;
         bit          held;
         r = '0;
         op = it.opcode;
         x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
         case (it.action)
            ACT_WRITE: mem[it.mem_address] = it.mem_write_data;
            ACT_READ:  r.read_byte = mem[it.mem_address];
            ACT_ROW:   r.row_pixels = scr[it.screen_row_select];
            default: begin
               case (op[15:12])
                  OPG_SYS: begin
                     if (op == OP_CLS) foreach (scr[i]) scr[i] = '0;
                     else if (op == OP_RET) begin
                        if (depth == 0) r.stack_fault = 1;
                        else begin
                           depth--;
                           pc = ret_stk[depth];
                        end
                     end
                  end
                  OPG_JP: pc = nnn;
                  OPG_CALL: begin
                     if (depth < 16) begin
                        ret_stk[depth] = pc;
                        depth++;
                        pc = nnn;
                     end else r.stack_fault = 1;
                  end
                  OPG_SE:   skip(v[x] == nn);
                  OPG_SNE:  skip(v[x] != nn);
                  OPG_SER:  if (n == 0) skip(v[x] == v[y]);
                  OPG_LD:   v[x] = nn;
                  OPG_ADD:  v[x] = v[x] + nn;
                  OPG_ALU:  run_alu(x, y, n);
                  OPG_SNER: if (n == 0) skip(v[x] != v[y]);
                  OPG_LDI:  idx = {4'd0, nnn};
                  OPG_JPV:  pc = 12'(v[0]) + nnn;
                  OPG_RND:  v[x] = it.random_byte & nn;
                  OPG_DRW: begin
                     draw(x, y, n);
                     r.redraw = 1;
                  end
                  OPG_KEY: begin
                     k = v[x];
                     held = (k <= 8'd15) && it.keys_down[k[3:0]];
                     if (nn == KEY_DOWN) skip(held);
                     else if (nn == KEY_UP) skip(!held);
                  end
                  default: begin
                     case (nn)
                        MSC_GETDT: v[x] = dt;
                        MSC_WAITK: begin
                           if (it.key_event_valid) v[x] = {4'd0, it.key_event_code};
                           else pc = pc - 12'd2;
                        end
                        MSC_SETDT: dt = v[x];
                        MSC_SETST: st = v[x];
                        MSC_ADDI:  idx = idx + 16'(v[x]);
                        MSC_FONT:  idx = 16'(v[x]) * 16'd5;
                        MSC_BCD: begin
                           mem[idx[11:0]] = v[x] / 100;
                           mem[12'(idx[11:0] + 1)] = (v[x] / 10) % 10;
                           mem[12'(idx[11:0] + 2)] = v[x] % 10;
                        end
                        MSC_STORE: begin
                           for (int i = 0; i <= x; i++) mem[12'(idx[11:0] + i)] = v[i];
                           idx = idx + 16'(x) + 16'd1;
                        end
                        MSC_LOAD: begin
                           for (int i = 0; i <= x; i++) v[i] = mem[12'(idx[11:0] + i)];
                           idx = idx + 16'(x) + 16'd1;
                        end
                        default: ;
                     endcase
                  end
               endcase
            end
         endcase
         r.program_counter = pc;
         r.index_value = idx;
         r.delay_value = dt;
         r.sound_value = st;
         exp_q.push_back(r);
      endfunction

      function void check_result(res_type got);
         res_type e;
         if (exp_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item %h", got);
            return;
         end
         e = exp_q.pop_front();
         if (got.program_counter !== e.program_counter || got.index_value !== e.index_value ||
             got.read_byte !== e.read_byte || got.row_pixels !== e.row_pixels ||
             got.redraw !== e.redraw || got.stack_fault !== e.stack_fault ||
             got.delay_value !== e.delay_value || got.sound_value !== e.sound_value) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp pc=%h i=%h rb=%h row=%h rd=%b sf=%b dt=%h st=%h",
                         " | got pc=%h i=%h rb=%h row=%h rd=%b sf=%b dt=%h st=%h"},
                        e.program_counter, e.index_value, e.read_byte, e.row_pixels,
                        e.redraw, e.stack_fault, e.delay_value, e.sound_value,
                        got.program_counter, got.index_value, got.read_byte,
                        got.row_pixels, got.redraw, got.stack_fault, got.delay_value,
                        got.sound_value);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;

   c8_scoreboard sb = new();
   int send_idle_pct;
   int sink_stall_pct;
   int rsp_count;
   int hold_left;
   bit hold_done;

   chip8_execute_unit_top dut (.*);

   always #4 clock = ~clock;

   task automatic send(item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {2'b00, it.screen_row_select, it.mem_write_data, it.mem_address,
                     it.random_byte, it.key_event_code, it.key_event_valid,
                     it.keys_down, it.opcode};
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
   endtask

   function automatic item_type rand_fields();
      item_type it;
      it.action = ACT_EXEC;
      it.opcode = 16'($urandom);
      it.keys_down = 16'($urandom);
      it.key_event_valid = 1'($urandom);
      it.key_event_code = 4'($urandom);
      it.random_byte = 8'($urandom);
      it.mem_address = 12'($urandom);
      it.mem_write_data = 8'($urandom);
      it.screen_row_select = 5'($urandom);
      return it;
   endfunction

   task automatic exec_op(logic [15:0] op);
      item_type it;
      it = rand_fields();
      it.opcode = op;
      send(it);
   endtask

   task automatic mem_access(logic [1:0] act, logic [11:0] a, logic [7:0] d);
      item_type it;
      it = rand_fields();
      it.action = act;
      it.mem_address = a;
      it.mem_write_data = d;
      send(it);
   endtask

   // valid-looking opcodes most of the time, raw words otherwise
   function automatic logic [15:0] pick_opcode();
      logic [15:0] op;
      logic [7:0]  misc[9];
      misc = '{MSC_GETDT, MSC_WAITK, MSC_SETDT, MSC_SETST, MSC_ADDI,
               MSC_FONT, MSC_BCD, MSC_STORE, MSC_LOAD};
      op = 16'($urandom);
      if ($urandom_range(9) == 0) return op;
      case (op[15:12])
         OPG_SYS: op = ($urandom_range(1)) ? OP_CLS : OP_RET;
         OPG_LD:  if ($urandom_range(1)) op[7:0] = op[7:0] & 8'h1f;
         OPG_ALU: if (op[3:0] > ALU_SUBN) op[3:0] = ALU_SHL;
         OPG_KEY: op[7:0] = ($urandom_range(1)) ? KEY_DOWN : KEY_UP;
         OPG_MISC: op[7:0] = misc[$urandom_range(8)];
         default: ;
      endcase
      return op;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            res_type r;
            r.program_counter = rsp_tdata[11:0];
            r.index_value     = rsp_tdata[27:12];
            r.read_byte       = rsp_tdata[35:28];
            r.row_pixels      = rsp_tdata[99:36];
            r.redraw          = rsp_tdata[100];
            r.stack_fault     = rsp_tdata[101];
            r.delay_value     = rsp_tdata[109:102];
            r.sound_value     = rsp_tdata[117:110];
            sb.check_result(r);
            rsp_count++;
         end
         // one long hold-off so the unit backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_count >= 700 && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [3:0] subs[10];
      int         burst;
      bit         paused;
      subs = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
               ALU_SUBN, ALU_SHL, 4'hF};
      send_idle_pct = 10;
      sink_stall_pct = 58;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sprites at both ends of memory, drawn across both screen edges
      mem_access(ACT_WRITE, 12'h300, 8'hFF);
      mem_access(ACT_WRITE, 12'hFFF, 8'h81);
      exec_op(16'h613E);
      exec_op(16'h621F);
      exec_op(16'hA300);
      exec_op(16'hD122);
      exec_op(16'hD122);          // collision
      exec_op(16'hD120);          // zero height
      exec_op(16'hAFFF);
      exec_op(16'hD122);          // sprite address wraps
      mem_access(ACT_ROW, 12'h000, 8'h00);
      mem_access(ACT_READ, 12'hFFF, 8'h00);
      exec_op(16'h63FF);
      exec_op(16'h6480);
      foreach (subs[i]) exec_op({OPG_ALU, 4'h3, 4'h4, subs[i]});
      exec_op(16'h8F34);          // flag lands in VF itself
      exec_op(16'h2ABC);
      exec_op(16'h00EE);
      exec_op(16'h00EE);          // return with empty stack
      exec_op(16'hE39E);          // key number 0
      exec_op(16'hE3A1);
      exec_op(16'hF30A);
      exec_op(16'hF315);
      exec_op(16'hF318);
      exec_op(16'hF333);
      exec_op(16'hFF55);
      exec_op(16'hFF65);
      exec_op(16'hF329);
      exec_op(16'hF01E);
      exec_op(16'hBFFF);
      exec_op(16'hC3AA);
      exec_op(16'h00E0);
      exec_op(16'h0123);

      for (int i = 0; i < 2000; i++) begin
         // bursts advance i by several steps, so phases switch on ranges
         if (i >= 1400) begin
            send_idle_pct = 0;
            sink_stall_pct = 0;
         end else if (i >= 700) begin
            send_idle_pct = 58;
            sink_stall_pct = 10;
         end
         if (i >= 1000 && !paused) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            while (sb.exp_q.size() != 0) @(posedge clock);
         end
         if ($urandom_range(59) == 0) begin
            // run of calls past the stack depth, or returns past empty
            burst = $urandom_range(1);
            repeat (18) begin
               if (burst) exec_op({OPG_CALL, 12'($urandom)});
               else exec_op(OP_RET);
               i++;
            end
         end else begin
            case ($urandom_range(9))
               0: mem_access(ACT_WRITE, 12'($urandom), 8'($urandom));
               1: mem_access(ACT_READ, 12'($urandom), 8'($urandom));
               2: mem_access(ACT_ROW, 12'($urandom), 8'($urandom));
               default: exec_op(pick_opcode());
            endcase
         end
      end
      req_tvalid <= 1'b0;
      while (sb.exp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.exp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
